[src/sclk_pkg.sv]
package sclk_pkg;

   localparam int unsigned HoursMod   = 24;
   localparam int unsigned MinutesMod = 60;

   localparam logic [4:0] HOURS_RESET   = 5'd23;
   localparam logic [5:0] MINUTES_RESET = 6'd59;
   localparam logic [5:0] SECONDS_RESET = 6'd59;
   localparam logic [4:0] HOURS_LAST    = 5'(HoursMod - 1);
   localparam logic [5:0] MINUTES_LAST  = 6'(MinutesMod - 1);

   localparam logic [7:0] SEG_BLANK   = 8'hFF;
   localparam logic [7:0] SEG_DP_MASK = 8'hFE;

   typedef struct packed {
      logic second_tick;
      logic blink_tick;
      logic setup_switch;
      logic field_button;
      logic increment_button;
   } req_type;

   typedef struct packed {
      logic [7:0] seg_left_tens;
      logic [7:0] seg_left_ones;
      logic [7:0] seg_right_tens;
      logic [7:0] seg_right_ones;
      logic [4:0] hours_now;
      logic [5:0] minutes_now;
      logic [5:0] seconds_now;
      logic       in_setup;
      logic       shows_hours_minutes;
   } rsp_type;

   // Updated time and mode flags handed from the time keeper to the display encoder.
   typedef struct packed {
      logic [4:0] hours;
      logic [5:0] minutes;
      logic [5:0] seconds;
      logic       view_hm;
      logic       edit_first;
      logic       blink_phase;
      logic       setup;
   } view_type;

   // Active-low segments, decimal point in bit 0.
   function automatic logic [7:0] seg_digit(input logic [3:0] d);
      logic [7:0] s;
      case (d)
         4'd0:    s = 8'h03;
         4'd1:    s = 8'h9F;
         4'd2:    s = 8'h25;
         4'd3:    s = 8'h0D;
         4'd4:    s = 8'h99;
         4'd5:    s = 8'h49;
         4'd6:    s = 8'h41;
         4'd7:    s = 8'h1F;
         4'd8:    s = 8'h01;
         4'd9:    s = 8'h09;
         default: s = SEG_BLANK;
      endcase
      return s;
   endfunction

   // Tens digit of a value below 64.
   function automatic logic [3:0] tens_of(input logic [5:0] v);
      logic [3:0] t;
      if (v >= 6'd60)      t = 4'd6;
      else if (v >= 6'd50) t = 4'd5;
      else if (v >= 6'd40) t = 4'd4;
      else if (v >= 6'd30) t = 4'd3;
      else if (v >= 6'd20) t = 4'd2;
      else if (v >= 6'd10) t = 4'd1;
      else                 t = 4'd0;
      return t;
   endfunction

   function automatic logic [3:0] ones_of(input logic [5:0] v);
      logic [3:0] t;
      logic [5:0] ten_mul;
      t = tens_of(v);
      ten_mul = {t[2:0], 3'b000} - 6'd0 + {1'b0, t, 1'b0};
      return 4'(v - ten_mul);
   endfunction

endpackage

[src/sclk_time.sv]
module sclk_time (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  sclk_pkg::req_type  req,
   output sclk_pkg::view_type view
);

   logic [4:0] hours_ff, hours_in;
   logic [5:0] minutes_ff, minutes_in;
   logic [5:0] seconds_ff, seconds_in;
   logic       view_hm_ff, view_hm_in;
   logic       edit_first_ff, edit_first_in;
   logic       blink_ff, blink_in;
   logic       fld_last_ff, fld_last_in;
   logic       inc_last_ff, inc_last_in;
   logic       pending_ff, pending_in;
   logic       setup;

   assign setup = !req.setup_switch;

   always_comb begin
      hours_in      = hours_ff;
      minutes_in    = minutes_ff;
      seconds_in    = seconds_ff;
      view_hm_in    = view_hm_ff;
      edit_first_in = edit_first_ff;
      blink_in      = blink_ff ^ req.blink_tick;
      fld_last_in   = req.field_button;
      inc_last_in   = inc_last_ff;
      pending_in    = pending_ff;

      // advance the time, or hold a tick as one pending second while in setup
      if (setup) begin
         if (req.second_tick) pending_in = 1'b1;
      end else if (req.second_tick || pending_ff) begin
         pending_in = 1'b0;
         if (seconds_ff == sclk_pkg::MINUTES_LAST) begin
            seconds_in = '0;
            if (minutes_ff == sclk_pkg::MINUTES_LAST) begin
               minutes_in = '0;
               hours_in = (hours_ff == sclk_pkg::HOURS_LAST) ? '0 : hours_ff + 5'd1;
            end else begin
               minutes_in = minutes_ff + 6'd1;
            end
         end else begin
            seconds_in = seconds_ff + 6'd1;
         end
      end

      if (setup) begin
         if (fld_last_ff && !req.field_button) edit_first_in = !edit_first_ff;
         inc_last_in = req.increment_button;
         if (inc_last_ff && !req.increment_button) begin
            if (view_hm_ff && edit_first_in) begin
               hours_in = (hours_in == sclk_pkg::HOURS_LAST) ? '0 : hours_in + 5'd1;
            end else if (view_hm_ff != edit_first_in) begin
               minutes_in = (minutes_in == sclk_pkg::MINUTES_LAST) ? '0 : minutes_in + 6'd1;
            end else begin
               seconds_in = (seconds_in == sclk_pkg::MINUTES_LAST) ? '0 : seconds_in + 6'd1;
            end
         end
      end else begin
         if (fld_last_ff && !req.field_button) view_hm_in = !view_hm_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hours_ff      <= sclk_pkg::HOURS_RESET;
         minutes_ff    <= sclk_pkg::MINUTES_RESET;
         seconds_ff    <= sclk_pkg::SECONDS_RESET;
         view_hm_ff    <= 1'b1;
         edit_first_ff <= 1'b1;
         blink_ff      <= 1'b1;
         fld_last_ff   <= 1'b1;
         inc_last_ff   <= 1'b1;
         pending_ff    <= 1'b0;
      end else if (step) begin
         hours_ff      <= hours_in;
         minutes_ff    <= minutes_in;
         seconds_ff    <= seconds_in;
         view_hm_ff    <= view_hm_in;
         edit_first_ff <= edit_first_in;
         blink_ff      <= blink_in;
         fld_last_ff   <= fld_last_in;
         inc_last_ff   <= inc_last_in;
         pending_ff    <= pending_in;
      end
   end

   assign view.hours       = hours_in;
   assign view.minutes     = minutes_in;
   assign view.seconds     = seconds_in;
   assign view.view_hm     = view_hm_in;
   assign view.edit_first  = edit_first_in;
   assign view.blink_phase = blink_in;
   assign view.setup       = setup;

endmodule

[src/sclk_disp.sv]
module sclk_disp (
   input  sclk_pkg::view_type view,
   output sclk_pkg::rsp_type  rsp
);

   logic [5:0] left_val;
   logic [5:0] right_val;
   logic       blank_left;
   logic       blank_right;

   always_comb begin
      if (view.view_hm) begin
         left_val  = {1'b0, view.hours};
         right_val = view.minutes;
      end else begin
         left_val  = view.minutes;
         right_val = view.seconds;
      end
      blank_left  = view.setup && view.edit_first && !view.blink_phase;
      blank_right = view.setup && !view.edit_first && !view.blink_phase;

      rsp.seg_left_tens  = blank_left ? sclk_pkg::SEG_BLANK :
                           sclk_pkg::seg_digit(sclk_pkg::tens_of(left_val));
      rsp.seg_left_ones  = blank_left ? sclk_pkg::SEG_BLANK :
                           (sclk_pkg::seg_digit(sclk_pkg::ones_of(left_val))
                            & sclk_pkg::SEG_DP_MASK);
      rsp.seg_right_tens = blank_right ? sclk_pkg::SEG_BLANK :
                           sclk_pkg::seg_digit(sclk_pkg::tens_of(right_val));
      rsp.seg_right_ones = blank_right ? sclk_pkg::SEG_BLANK :
                           sclk_pkg::seg_digit(sclk_pkg::ones_of(right_val));
      rsp.hours_now           = view.hours;
      rsp.minutes_now         = view.minutes;
      rsp.seconds_now         = view.seconds;
      rsp.in_setup            = view.setup;
      rsp.shows_hours_minutes = view.view_hm;
   end

endmodule

[src/settable_clock_seven_segment_unit.sv]
// Settable 24-hour clock driving a four-digit seven-segment display.
// Each request on the req_ channel is one sample of the one-second tick, the
// half-second blink tick and the raw active-low setup switch, field button and
// increment button. Each request yields exactly one response on the rsp_
// channel: four active-low segment bytes (left pair, right pair, colon as the
// decimal point of the second digit) plus the current time and mode flags.
// Latency: a request taken is held in the input register, and its response is
// computed from it and registered in the response register, which drives
// rsp_valid; while rsp_ready is low the request can wait in the input register.
// Throughput: one request per cycle while rsp_ready is high; the time update
// and the segment decode sit between the input register and the response register.
// Stalls: while rsp_ready is low the response register holds its value; the
// input register keeps one more request, and req_ready drops only when both
// registers are full.
// Reset: time goes to 23:59:59, HH:MM view, first field selected, blink phase
// on, buttons released, no pending second; both registers empty.
module settable_clock_seven_segment_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sclk_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sclk_pkg::rsp_type rsp_payload
);

   logic              in_valid_ff, in_valid_in;
   sclk_pkg::req_type in_data_ff;
   logic              out_valid_ff, out_valid_in;
   sclk_pkg::rsp_type out_data_ff;
   logic              out_free;
   logic              advance;
   sclk_pkg::view_type view;
   sclk_pkg::rsp_type  rsp_next;

   // response register can load when empty or being drained this cycle
   assign out_free  = !out_valid_ff || rsp_ready;
   // move the held request through the clock update into the response register
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers: load on handshake, otherwise hold
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_data_ff <= req_payload;
      if (advance) out_data_ff <= rsp_next;
   end

   sclk_time u_time (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .req   (in_data_ff),
      .view  (view)
   );

   sclk_disp u_disp (
      .view (view),
      .rsp  (rsp_next)
   );

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

   // time fields stay in range on every offered response
   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.hours_now <= 5'd23 && rsp_payload.minutes_now <= 6'd59
                     && rsp_payload.seconds_now <= 6'd59))
      else $error("time field out of range");

   // outside setup nothing blanks, so the colon is always lit
   a_colon_lit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.in_setup) |-> (rsp_payload.seg_left_ones[0] == 1'b0
                                              && rsp_payload.seg_right_ones != 8'hFF))
      else $error("digit blanked in normal mode");

   // only one pair of digits blinks at a time
   a_one_pair_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload.seg_left_tens == 8'hFF && rsp_payload.seg_right_tens == 8'hFF))
      else $error("both digit pairs blanked");

   // a held request moves on as soon as the response side has room
   a_no_stuck: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_free) |=> out_valid_ff)
      else $error("request lost between registers");

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;

   // Active-low glyphs for the decimal digits, decimal point in bit 0.
   localparam logic [7:0] GLYPH [10] = '{
      8'h03, 8'h9F, 8'h25, 8'h0D, 8'h99, 8'h49, 8'h41, 8'h1F, 8'h01, 8'h09
   };
   localparam int HOLD_CYCLES = 60;

   // Drive every input to a known level from time zero.
   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   sclk_pkg::req_type req_payload = '1;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   sclk_pkg::rsp_type rsp_payload;

   settable_clock_seven_segment_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Shadow copy of the clock state, starting at the post-reset values.
   logic [4:0] hrs       = sclk_pkg::HOURS_RESET;
   logic [5:0] mins      = sclk_pkg::MINUTES_RESET;
   logic [5:0] secs      = sclk_pkg::SECONDS_RESET;
   logic       view_hm   = 1'b1;
   logic       edit_one  = 1'b1;
   logic       blink_on  = 1'b1;
   logic       fld_prev  = 1'b1;
   logic       inc_prev  = 1'b1;
   logic       sec_owed  = 1'b0;

   sclk_pkg::req_type pending_samples[$];
   sclk_pkg::rsp_type expected_readouts[$];
   int                failures = 0;

   // Handshake bookkeeping shared between the driver, the receiver, the monitor and the sequencer.
   logic req_taken = 1'b0;
   int   send_idle_pct = 0;
   int   stall_pct = 0;
   bit   hold_arm = 1'b0;
   int   hold_left = 0;

   // Current raw levels of the controls for the random sessions.
   logic lvl_setup = 1'b1;
   logic lvl_field = 1'b1;
   logic lvl_inc   = 1'b1;

   function automatic logic [5:0] wrap_sixty(input logic [5:0] v);
      return (v == sclk_pkg::MINUTES_LAST) ? 6'd0 : v + 6'd1;
   endfunction

   // Apply one sample to the shadow state and form the display it produces.
   function automatic sclk_pkg::rsp_type advance_clock(input sclk_pkg::req_type s);
      sclk_pkg::rsp_type r;
      logic              in_set;
      logic              blank_l;
      logic              blank_r;
      logic [5:0]        left_val;
      logic [5:0]        right_val;
      in_set = !s.setup_switch;
      if (s.blink_tick) blink_on = !blink_on;

      // Ticks during setup collapse into one owed second.
      if (in_set) begin
         if (s.second_tick) sec_owed = 1'b1;
      end else if (s.second_tick || sec_owed) begin
         sec_owed = 1'b0;
         secs = wrap_sixty(secs);
         if (secs == 6'd0) begin
            mins = wrap_sixty(mins);
            if (mins == 6'd0) hrs = (hrs == sclk_pkg::HOURS_LAST) ? 5'd0 : hrs + 5'd1;
         end
      end

      // The increment level is only sampled while in setup.
      if (in_set) begin
         if (fld_prev && !s.field_button) edit_one = !edit_one;
         fld_prev = s.field_button;
         if (inc_prev && !s.increment_button) begin
            if (view_hm && edit_one)
               hrs = (hrs == sclk_pkg::HOURS_LAST) ? 5'd0 : hrs + 5'd1;
            else if (view_hm || edit_one)
               mins = wrap_sixty(mins);
            else
               secs = wrap_sixty(secs);
         end
         inc_prev = s.increment_button;
      end else begin
         if (fld_prev && !s.field_button) view_hm = !view_hm;
         fld_prev = s.field_button;
      end

      left_val  = view_hm ? {1'b0, hrs} : mins;
      right_val = view_hm ? mins : secs;
      blank_l = in_set && edit_one && !blink_on;
      blank_r = in_set && !edit_one && !blink_on;

      r.seg_left_tens  = blank_l ? sclk_pkg::SEG_BLANK : GLYPH[left_val / 10];
      r.seg_left_ones  = blank_l ? sclk_pkg::SEG_BLANK :
                         (GLYPH[left_val % 10] & sclk_pkg::SEG_DP_MASK);
      r.seg_right_tens = blank_r ? sclk_pkg::SEG_BLANK : GLYPH[right_val / 10];
      r.seg_right_ones = blank_r ? sclk_pkg::SEG_BLANK : GLYPH[right_val % 10];
      r.hours_now           = hrs;
      r.minutes_now         = mins;
      r.seconds_now         = secs;
      r.in_setup            = in_set;
      r.shows_hours_minutes = view_hm;
      return r;
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         failures++;
      end
   endfunction

   function automatic sclk_pkg::req_type sample(input logic tick, input logic blink,
                                                input logic sw, input logic fld,
                                                input logic inc);
      sclk_pkg::req_type s;
      s.second_tick      = tick;
      s.blink_tick       = blink;
      s.setup_switch     = sw;
      s.field_button     = fld;
      s.increment_button = inc;
      return s;
   endfunction

   // Random sessions: controls hold their levels for runs and flip now and then,
   // so setup periods last long enough for real edits; a tenth is pure noise.
   task automatic queue_random(input int count);
      sclk_pkg::req_type s;
      repeat (count) begin
         if ($urandom_range(9) == 0) begin
            s = sclk_pkg::req_type'(5'($urandom_range(31)));
         end else begin
            if ($urandom_range(24) == 0) lvl_setup = !lvl_setup;
            if ($urandom_range(4) == 0)  lvl_field = !lvl_field;
            if ($urandom_range(2) == 0)  lvl_inc   = !lvl_inc;
            s = sample(1'($urandom_range(1)), $urandom_range(2) == 0,
                       lvl_setup, lvl_field, lvl_inc);
         end
         pending_samples.push_back(s);
      end
   endtask

   // Wait until every queued request is taken and every readout has come back.
   task automatic drain_readouts();
      while (pending_samples.size() != 0 || expected_readouts.size() != 0 || req_valid)
         @(posedge clock);
      @(posedge clock);
   endtask

   // Driver: present the next request at the falling edge, or idle at random.
   // Hold valid and payload steady until the request is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_payload <= pending_samples.pop_front();
            req_valid   <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: stall at random, or hold off for a long stretch when armed.
   always @(negedge clock) begin
      if (hold_arm) begin
         hold_arm  = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Monitor: check each readout against the oldest prediction, then predict
   // the readout for any request taken at this edge.
   always @(posedge clock) begin : watch_readouts
      sclk_pkg::rsp_type want;
      req_taken <= req_valid && req_ready && !reset;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_readouts.size() == 0) begin
               $error("readout with no request outstanding");
               failures++;
            end else begin
               want = expected_readouts.pop_front();
               check_field("seg_left_tens", want.seg_left_tens, rsp_payload.seg_left_tens);
               check_field("seg_left_ones", want.seg_left_ones, rsp_payload.seg_left_ones);
               check_field("seg_right_tens", want.seg_right_tens,
                           rsp_payload.seg_right_tens);
               check_field("seg_right_ones", want.seg_right_ones,
                           rsp_payload.seg_right_ones);
               check_field("hours_now", want.hours_now, rsp_payload.hours_now);
               check_field("minutes_now", want.minutes_now, rsp_payload.minutes_now);
               check_field("seconds_now", want.seconds_now, rsp_payload.seconds_now);
               check_field("in_setup", want.in_setup, rsp_payload.in_setup);
               check_field("shows_hours_minutes", want.shows_hours_minutes,
                           rsp_payload.shows_hours_minutes);
            end
         end
         if (req_valid && req_ready)
            expected_readouts.push_back(advance_clock(req_payload));
      end
   end

   // Sequencer: reset, a directed walk, then random sessions under each idling mix.
   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed walk from 23:59:59 (tick, blink, switch, field, increment).
      pending_samples.push_back(sample(1'b0, 1'b0, 1'b1, 1'b1, 1'b1)); // idle in normal mode
      pending_samples.push_back(sample(1'b0, 1'b1, 1'b0, 1'b1, 1'b1)); // enter setup, hours blank
      pending_samples.push_back(sample(1'b1, 1'b0, 1'b0, 1'b1, 1'b0)); // hours wrap to 0, tick owed
      pending_samples.push_back(sample(1'b1, 1'b1, 1'b0, 1'b1, 1'b1)); // second tick still one owed
      pending_samples.push_back(sample(1'b0, 1'b0, 1'b0, 1'b0, 1'b1)); // pick minutes
      pending_samples.push_back(sample(1'b0, 1'b1, 1'b0, 1'b0, 1'b0)); // minutes wrap, right blank
      pending_samples.push_back(sample(1'b0, 1'b0, 1'b0, 1'b1, 1'b1)); // release both
      pending_samples.push_back(sample(1'b1, 1'b0, 1'b1, 1'b1, 1'b1)); // leave: tick plus owed = one
      pending_samples.push_back(sample(1'b0, 1'b0, 1'b1, 1'b1, 1'b0)); // increment ignored
      pending_samples.push_back(sample(1'b0, 1'b0, 1'b0, 1'b1, 1'b0)); // held press counts
      pending_samples.push_back(sample(1'b0, 1'b0, 1'b0, 1'b1, 1'b1));
      pending_samples.push_back(sample(1'b0, 1'b0, 1'b1, 1'b1, 1'b1)); // leave with nothing owed
      pending_samples.push_back(sample(1'b0, 1'b0, 1'b1, 1'b0, 1'b1)); // swap to MM:SS
      pending_samples.push_back(sample(1'b0, 1'b0, 1'b1, 1'b1, 1'b1));
      pending_samples.push_back(sample(1'b0, 1'b0, 1'b0, 1'b1, 1'b1)); // setup in MM:SS view
      pending_samples.push_back(sample(1'b0, 1'b0, 1'b0, 1'b0, 1'b1)); // pick minutes
      pending_samples.push_back(sample(1'b0, 1'b1, 1'b0, 1'b0, 1'b0)); // minutes step
      pending_samples.push_back(sample(1'b0, 1'b0, 1'b0, 1'b1, 1'b1));
      pending_samples.push_back(sample(1'b0, 1'b0, 1'b0, 1'b0, 1'b1)); // pick seconds
      pending_samples.push_back(sample(1'b1, 1'b1, 1'b0, 1'b0, 1'b0)); // seconds step, tick owed
      pending_samples.push_back(sample(1'b0, 1'b0, 1'b0, 1'b1, 1'b1));
      pending_samples.push_back(sample(1'b0, 1'b1, 1'b1, 1'b0, 1'b1)); // leave, swap back, owed
      pending_samples.push_back(sample(1'b1, 1'b1, 1'b1, 1'b1, 1'b1)); // plain tick
      drain_readouts();

      // Long receiver hold-off while requests keep coming: fill and stall the input.
      hold_arm = 1'b1;
      queue_random(40);
      drain_readouts();

      send_idle_pct = 83;
      queue_random(200);
      drain_readouts();

      send_idle_pct = 0;
      stall_pct = 83;
      queue_random(200);
      drain_readouts();

      send_idle_pct = 8;
      stall_pct = 8;
      queue_random(200);
      drain_readouts();

      send_idle_pct = 0;
      stall_pct = 0;
      queue_random(190);
      drain_readouts();

      // Let any stray readout surface before the verdict.
      repeat (8) @(posedge clock);
      if (failures == 0 && expected_readouts.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Watchdog: give up well past the slowest legal run.
   initial begin
      #5000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
